FILE: rtl/wsd_pkg.sv
package wsd_pkg;

	localparam int IN_W       = 8;
	localparam int LEN_W      = 63;
	localparam int CFG_W      = 63;
	localparam int CFG_IDX_W  = 1;
	localparam int TDATA_W    = 80;
	localparam int TUSER_W    = 2;
	localparam int KEY_W      = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 1'd1;

	// Seven-bit length codes that announce an extended length field.
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;
	localparam int KEY_BYTES = 4;

	// Field byte counts minus one, loaded when a multi-byte field starts.
	localparam logic [2:0] EXT16_LAST = 3'd1;
	localparam logic [2:0] EXT64_LAST = 3'd7;
	localparam logic [2:0] KEY_LAST   = 3'(KEY_BYTES - 1);

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_TOO_LONG = 2'd2
	} wsd_kind_t;

	typedef struct packed {
		wsd_kind_t         kind;
		logic [7:0]        raw;
		logic [7:0]        key_byte;
		logic [3:0]        opcode;
		logic              fin;
		logic              masked;
		logic [LEN_W-1:0]  length;
		logic              last;
	} wsd_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wsd_qstat_t;

endpackage

FILE: rtl/wsd_parser.sv
module wsd_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wsd_pkg::IN_W-1:0]       s_tdata,
	input  logic                           cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsd_pkg::CFG_W-1:0]      cfg_data,
	input  wsd_pkg::wsd_qstat_t            q_stat,
	output logic                           push,
	output wsd_pkg::wsd_rec_t              rec
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		ST_HDR0,
		ST_HDR1,
		ST_EXT,
		ST_KEY,
		ST_PAY
	} state_t;

	state_t             st_q, st_d;
	logic               fin_q, fin_d;
	logic [3:0]         op_q, op_d;
	logic               mask_q, mask_d;
	logic [LEN_W-1:0]   acc_q, acc_d;
	logic [2:0]         cnt_q, cnt_d;
	logic [KEY_W-1:0]   key_q, key_d;
	logic [LEN_W-1:0]   rem_q, rem_d;
	logic [1:0]         kidx_q, kidx_d;
	logic               disc_q, disc_d;
	logic               limit_q;
	logic [LEN_W-1:0]   max_q;

	logic               accept;
	logic               emit;
	logic               len_done;
	logic               enter_pay;
	logic               too_long;
	logic [LEN_W-1:0]   len_val;
	logic [7:0]         kb;
	logic [7:0]         b;

	assign b        = s_tdata;
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && emit;

	always_comb begin
		case (kidx_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
		if (!mask_q) begin
			kb = 8'h00;
		end
	end

	always_comb begin
		st_d      = st_q;
		fin_d     = fin_q;
		op_d      = op_q;
		mask_d    = mask_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		rem_d     = rem_q;
		kidx_d    = kidx_q;
		disc_d    = disc_q;
		len_done  = 1'b0;
		enter_pay = 1'b0;
		too_long  = 1'b0;
		len_val   = acc_q;
		emit      = 1'b0;
		rec.kind     = KIND_PAYLOAD;
		rec.raw      = 8'h00;
		rec.key_byte = 8'h00;
		rec.last     = 1'b1;

		case (st_q)
			ST_HDR1: begin
				mask_d = b[7];
				acc_d  = '0;
				if (b[6:0] == LEN16_CODE) begin
					cnt_d = EXT16_LAST;
					st_d  = ST_EXT;
				end else if (b[6:0] == LEN64_CODE) begin
					cnt_d = EXT64_LAST;
					st_d  = ST_EXT;
				end else begin
					len_val  = LEN_W'(b[6:0]);
					len_done = 1'b1;
				end
			end
			ST_EXT: begin
				// Only the low 63 bits are kept; the reserved top bit falls off.
				len_val = {acc_q[LEN_W-9:0], b};
				acc_d   = len_val;
				if (cnt_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			ST_KEY: begin
				key_d = {key_q[KEY_W-9:0], b};
				if (cnt_q == 3'd0) begin
					enter_pay = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			ST_PAY: begin
				if (rem_q == '0) begin
					st_d = ST_HDR0;
				end else begin
					rem_d  = rem_q - LEN_W'(1);
					kidx_d = kidx_q + 2'd1;
					if (rem_q == LEN_W'(1)) begin
						st_d = ST_HDR0;
					end
					emit         = !disc_q;
					rec.kind     = KIND_PAYLOAD;
					rec.raw      = b;
					rec.key_byte = kb;
					rec.last     = (rem_q == LEN_W'(1));
				end
			end
			default: begin
				fin_d  = b[7];
				op_d   = b[3:0];
				mask_d = 1'b0;
				key_d  = '0;
				acc_d  = '0;
				rem_d  = '0;
				kidx_d = 2'd0;
				disc_d = 1'b0;
				cnt_d  = 3'd0;
				st_d   = ST_HDR1;
			end
		endcase

		if (len_done) begin
			too_long = limit_q && (len_val > max_q);
			acc_d    = len_val;
			rem_d    = len_val;
			kidx_d   = 2'd0;
			disc_d   = too_long;
			if (too_long) begin
				emit     = 1'b1;
				rec.kind = KIND_TOO_LONG;
			end
			if (mask_d) begin
				st_d  = ST_KEY;
				cnt_d = KEY_LAST;
			end else begin
				enter_pay = 1'b1;
			end
		end

		if (enter_pay) begin
			if (rem_d == '0) begin
				st_d = ST_HDR0;
				if (!disc_d) begin
					emit     = 1'b1;
					rec.kind = KIND_EMPTY;
				end
			end else begin
				st_d = ST_PAY;
			end
		end

		rec.opcode = op_q;
		rec.fin    = fin_q;
		rec.masked = mask_d;
		rec.length = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_HDR0;
			fin_q   <= 1'b0;
			op_q    <= 4'd0;
			mask_q  <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= 3'd0;
			key_q   <= '0;
			rem_q   <= '0;
			kidx_q  <= 2'd0;
			disc_q  <= 1'b0;
			limit_q <= 1'b0;
			max_q   <= '1;
		end else begin
			if (accept) begin
				st_q   <= st_d;
				fin_q  <= fin_d;
				op_q   <= op_d;
				mask_q <= mask_d;
				acc_q  <= acc_d;
				cnt_q  <= cnt_d;
				key_q  <= key_d;
				rem_q  <= rem_d;
				kidx_q <= kidx_d;
				disc_q <= disc_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LIMIT_ENABLE: limit_q <= cfg_data[0];
					REG_MAX_LENGTH:   max_q   <= cfg_data;
					default:          ;
				endcase
			end
		end
	end

endmodule

FILE: rtl/wsd_queue.sv
module wsd_queue #(
	parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsd_pkg::wsd_rec_t    push_rec,
	input  logic                 pop,
	output wsd_pkg::wsd_rec_t    head_rec,
	output wsd_pkg::wsd_qstat_t  q_stat
);
	import wsd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wsd_rec_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/wsd_emit.sv
module wsd_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsd_pkg::wsd_rec_t             head_rec,
	input  wsd_pkg::wsd_qstat_t           q_stat,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [wsd_pkg::TDATA_W-1:0]   m_tdata,
	output logic [wsd_pkg::TUSER_W-1:0]   m_tuser,
	output logic                          m_tlast
);
	import wsd_pkg::*;

	logic              vld_q;
	wsd_kind_t         kind_q;
	logic [7:0]        data_q;
	logic [3:0]        op_q;
	logic              fin_q;
	logic              masked_q;
	logic [LEN_W-1:0]  len_q;
	logic              last_q;

	assign pop = !q_stat.empty && (!vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	// Unmasking happens here, on the way into the output register.
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head_rec.kind;
			data_q   <= head_rec.raw ^ head_rec.key_byte;
			op_q     <= head_rec.opcode;
			fin_q    <= head_rec.fin;
			masked_q <= head_rec.masked;
			len_q    <= head_rec.length;
			last_q   <= head_rec.last;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = TDATA_W'({len_q, masked_q, fin_q, op_q, data_q});

endmodule

FILE: rtl/websocket_frame_deframer.sv
// Channel  Direction  Data                                     Side band
// s_*      in         tdata[7:0] rx_byte                       -
// m_*      out        tdata: data_byte, opcode, fin,           tuser: kind
//                     was_masked, frame_length                 tlast: last
// cfg_*    in         cfg_index selects register, cfg_data     -
//
// One received byte is taken per cycle while the queue has room; header and key
// bytes produce no payload transfer. A result reaches m_* through the queue and the
// output register; the parser and its 63-bit length compare set the one-byte pace.
// s_tready drops only when the queue is full, which happens after a sustained stall
// on m_tready. Reset clears the parser to the first header byte and empties the queue.
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wsd_pkg::IN_W-1:0]       s_tdata,    // [7:0] rx_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] data_byte, [11:8] opcode, [12] fin, [13] was_masked,
	// [76:14] frame_length, [79:77] zero
	output logic [wsd_pkg::TDATA_W-1:0]    m_tdata,
	output logic [wsd_pkg::TUSER_W-1:0]    m_tuser,    // [1:0] kind
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsd_pkg::CFG_W-1:0]      cfg_data
);
	import wsd_pkg::*;

	wsd_qstat_t  q_stat;
	wsd_rec_t    push_rec;
	wsd_rec_t    head_rec;
	logic        push;
	logic        pop;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.rec       (push_rec)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.q_stat   (q_stat)
	);

	wsd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_rec (head_rec),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// Empty-frame and too-long results always close their frame.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_PAYLOAD) |-> m_tlast)
		else $error("status result without last");

	// Only payload transfers carry a data byte.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'h00))
		else $error("status result with nonzero data byte");

	// A queued result reaches an empty output register in the next cycle.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty && !m_tvalid |=> m_tvalid)
		else $error("queued result not moved to the output");

	// The parser never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");
`endif

endmodule
